// ===== hdl/clrle_pkg.sv =====
// Package for the code-length run-length encoder.
// Holds widths, symbol codes, thresholds and the queued run record.
// No dependencies.
package clrle_pkg;

	// Longest run accepted; longer runs saturate to this
	localparam int unsigned MAX_RUN    = 320;
	// Most symbols sent for one run
	localparam int unsigned RESULT_CAP = 55;

	localparam int unsigned LEN_W  = 4;
	localparam int unsigned CNT_IN_W = 9;
	localparam int unsigned SYM_W  = 5;
	localparam int unsigned REP_W  = 8;
	localparam int unsigned RUN_W  = (MAX_RUN + 1 > (1 << CNT_IN_W)) ?
		$clog2(MAX_RUN + 1) : CNT_IN_W;
	localparam int unsigned CAP_W  = $clog2(RESULT_CAP + 1);

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = 1;
	localparam int unsigned QCNT_W = 2;

	// Code-length alphabet
	localparam logic [SYM_W-1:0] SYM_REP_PREV   = SYM_W'(16);
	localparam logic [SYM_W-1:0] SYM_ZERO_SHORT = SYM_W'(17);
	localparam logic [SYM_W-1:0] SYM_ZERO_LONG  = SYM_W'(18);

	// Run thresholds
	localparam logic [RUN_W-1:0] RUN_MAX_C    = RUN_W'(MAX_RUN);
	localparam logic [RUN_W-1:0] LIT_LIMIT    = RUN_W'(3);   // below: literals
	localparam logic [RUN_W-1:0] REP_LIMIT    = RUN_W'(7);   // below: one 16 ends it
	localparam logic [RUN_W-1:0] REP_MAX      = RUN_W'(6);
	localparam logic [RUN_W-1:0] ZSHORT_LIMIT = RUN_W'(11);
	localparam logic [RUN_W-1:0] ZLONG_LIMIT  = RUN_W'(139);
	localparam logic [RUN_W-1:0] ZLONG_MAX    = RUN_W'(138);

	typedef struct packed {
		logic             zero;
		logic [LEN_W-1:0] len;
		logic [RUN_W-1:0] left;
	} run_t;

endpackage

// ===== hdl/clrle_front.sv =====
// Front end: accepts runs, saturates the count and drops empty runs.
// Depends on clrle_pkg.
module clrle_front import clrle_pkg::*; (
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [LEN_W-1:0]    code_length,
	input  logic [CNT_IN_W-1:0] run_count,
	input  logic                q_full,
	output logic                q_push,
	output run_t                q_data
);

	logic [RUN_W-1:0] cnt_ext;

	// queue full comes straight from the count register
	assign in_ready = !q_full;
	assign cnt_ext  = RUN_W'(run_count);

	always_comb begin
		q_data.zero = (code_length == '0);
		q_data.len  = code_length;
		q_data.left = (cnt_ext > RUN_MAX_C) ? RUN_MAX_C : cnt_ext;
		// A run of zero symbols produces nothing
		q_push      = in_valid && in_ready && (run_count != '0);
	end

endmodule

// ===== hdl/clrle_queue.sv =====
// Two-entry queue of classified runs between front and back end.
// Depends on clrle_pkg.
module clrle_queue import clrle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t wdata,
	output logic full,
	input  logic pop,
	output run_t rdata,
	output logic empty
);

	run_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/clrle_back.sv =====
// Back end: walks one queued run, one symbol per cycle unless the output stalls, into an output register.
// Depends on clrle_pkg.
module clrle_back import clrle_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  run_t              q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SYM_W-1:0]  symbol,
	output logic [REP_W-1:0]  repeat_res,
	output logic              last
);

	logic             busy_q;
	logic             first_q;
	logic             zero_q;
	logic [LEN_W-1:0] len_q;
	logic [RUN_W-1:0] left_q;
	logic [CAP_W-1:0] cnt_q;

	logic             ovalid_q;
	logic [SYM_W-1:0] sym_q;
	logic [REP_W-1:0] rep_q;
	logic             last_q;

	logic             can_emit;
	logic             step;
	logic [SYM_W-1:0] nsym;
	logic [REP_W-1:0] nrep;
	logic [RUN_W-1:0] nleft;
	logic             ndone;

	assign can_emit = !ovalid_q || out_ready;
	assign step     = busy_q && can_emit;
	assign q_pop    = !busy_q && !q_empty;

	always_comb begin
		nsym  = SYM_W'(len_q);
		nrep  = REP_W'(1);
		nleft = left_q - 1'b1;
		if (zero_q) begin
			if (left_q < LIT_LIMIT) begin
				nsym = '0;
			end else if (left_q < ZSHORT_LIMIT) begin
				nsym  = SYM_ZERO_SHORT;
				nrep  = left_q[REP_W-1:0];
				nleft = '0;
			end else if (left_q < ZLONG_LIMIT) begin
				nsym  = SYM_ZERO_LONG;
				nrep  = left_q[REP_W-1:0];
				nleft = '0;
			end else begin
				nsym  = SYM_ZERO_LONG;
				nrep  = ZLONG_MAX[REP_W-1:0];
				nleft = left_q - ZLONG_MAX;
			end
		end else if (!(first_q || left_q < LIT_LIMIT)) begin
			// first symbol of a nonzero run is always the literal itself
			nsym = SYM_REP_PREV;
			if (left_q < REP_LIMIT) begin
				nrep  = left_q[REP_W-1:0];
				nleft = '0;
			end else begin
				nrep  = REP_MAX[REP_W-1:0];
				nleft = left_q - REP_MAX;
			end
		end
		ndone = (nleft == '0) || (cnt_q == CAP_W'(RESULT_CAP - 1));
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			zero_q <= q_data.zero;
			len_q  <= q_data.len;
		end
		if (step) begin
			sym_q  <= nsym;
			rep_q  <= nrep;
			last_q <= ndone;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			first_q  <= 1'b0;
			left_q   <= '0;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				left_q  <= q_data.left;
				cnt_q   <= '0;
			end else if (step) begin
				busy_q  <= !ndone;
				first_q <= 1'b0;
				left_q  <= nleft;
				cnt_q   <= cnt_q + 1'b1;
			end
			if (step) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = ovalid_q;
	assign symbol     = sym_q;
	assign repeat_res = rep_q;
	assign last       = last_q;

endmodule

// ===== hdl/code_length_run_length_encoder.sv =====
// Code-length run-length encoder, top level.
// Depends on clrle_pkg, clrle_front, clrle_queue, clrle_back.
//
// Usage:
//  - Input channel (in_valid/in_ready, code_length, run_count): one transfer
//    carries one run of equal Huffman code lengths. run_count above MAX_RUN
//    saturates; a run_count of zero is taken and yields no symbols.
//  - Output channel (out_valid/out_ready, symbol, repeat_res, last): one
//    transfer per code-length symbol, last set on the final symbol of a run.
//  - Front end classifies runs into a two-entry queue; the back end walks the
//    run at the head of the queue, one symbol per cycle while the receiver is
//    ready, into an output register, so input transfers keep flowing while the
//    receiver stalls until the queue is full.
//  - Path: when the back end is free, the first symbol of a run passes the
//    queue write, then the load into the walker, then the output register.
//  - Runs: the walker loads a run, then emits its N symbols (N up to 55 at
//    the default MAX_RUN); the single symbol walker in the back end takes a
//    new run only after the last symbol of the current one.
//  - Reset (arst_n low) empties the queue, drops any run in progress and
//    clears out_valid. A stalled receiver holds the output register and the
//    walker; nothing is dropped.
module code_length_run_length_encoder import clrle_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [LEN_W-1:0]    code_length,
	input  logic [CNT_IN_W-1:0] run_count,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SYM_W-1:0]    symbol,
	output logic [REP_W-1:0]    repeat_res,
	output logic                last
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	run_t q_wdata;
	run_t q_rdata;

	// front end: accept and classify
	clrle_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.code_length (code_length),
		.run_count   (run_count),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	// decoupling queue
	clrle_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// back end: symbol walker and output register
	clrle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_data     (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.symbol     (symbol),
		.repeat_res (repeat_res),
		.last       (last)
	);

endmodule

// ===== hdl/clrle_checker.sv =====
// Port-level checks for the code-length run-length encoder, bound to the top.
// Depends on clrle_pkg.
module clrle_checker import clrle_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SYM_W-1:0]    symbol,
	input logic [REP_W-1:0]    repeat_res,
	input logic                last
);

	// stalled output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(symbol) &&
		$stable(repeat_res) && $stable(last))
		else $error("output changed while stalled");

	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> symbol <= SYM_ZERO_LONG)
		else $error("symbol out of alphabet");

	a_lit_rep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && symbol < SYM_REP_PREV |-> repeat_res == REP_W'(1))
		else $error("literal with repeat other than one");

	a_rep16: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && symbol == SYM_REP_PREV |->
		repeat_res >= REP_W'(3) && repeat_res <= REP_W'(6))
		else $error("symbol 16 repeat out of range");

	a_zero_rep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (symbol == SYM_ZERO_SHORT || symbol == SYM_ZERO_LONG) |->
		(symbol == SYM_ZERO_SHORT && repeat_res >= REP_W'(3) &&
		repeat_res <= REP_W'(10)) ||
		(symbol == SYM_ZERO_LONG && repeat_res >= REP_W'(11) &&
		repeat_res <= REP_W'(138)))
		else $error("zero run repeat out of range");

endmodule

bind code_length_run_length_encoder clrle_checker u_clrle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.symbol     (symbol),
	.repeat_res (repeat_res),
	.last       (last)
);
